// ===== sv/rbce_pkg.sv =====
// Shared types and constants for the ray-box closest edge hit block.
package rbce_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEN1,
      ST_LEN2,
      ST_EDGE,
      ST_MUL,
      ST_DIV,
      ST_CHK,
      ST_SQ1,
      ST_SQ2,
      ST_OUT
   } back_state_type;

   localparam logic [1:0] SIDE_TOP    = 2'd0;
   localparam logic [1:0] SIDE_BOTTOM = 2'd1;
   localparam logic [1:0] SIDE_LEFT   = 2'd2;
   localparam logic [1:0] SIDE_RIGHT  = 2'd3;

   localparam int FAR_SHIFT = 40;

endpackage

// ===== sv/rbce_front.sv =====
// Front stage: accepts requests and marks the edges that cannot be hit.
module rbce_front
   import rbce_pkg::*;
#(
   parameter int CW = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [8*CW-1:0] req_tdata,
   output logic            item_valid,
   input  logic            item_ready,
   output logic [8*CW-1:0] item_data,
   output logic [3:0]      item_mask
);

   logic            valid_ff, valid_in;
   logic [8*CW-1:0] data_ff;
   logic [3:0]      mask_ff, mask_in;
   logic [CW-1:0]   x1, y1, x2, y2, bl, bt, br, bb;
   logic            take;

   assign x1 = req_tdata[0*CW +: CW];
   assign y1 = req_tdata[1*CW +: CW];
   assign x2 = req_tdata[2*CW +: CW];
   assign y2 = req_tdata[3*CW +: CW];
   assign bl = req_tdata[4*CW +: CW];
   assign bt = req_tdata[5*CW +: CW];
   assign br = req_tdata[6*CW +: CW];
   assign bb = req_tdata[7*CW +: CW];

   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;

   // A set mask bit means a parallel ray or a zero-length edge.
   always_comb begin
      mask_in[SIDE_TOP]    = (y1 == y2) || (bl == br);
      mask_in[SIDE_BOTTOM] = (y1 == y2) || (bl == br);
      mask_in[SIDE_LEFT]   = (x1 == x2) || (bt == bb);
      mask_in[SIDE_RIGHT]  = (x1 == x2) || (bt == bb);
      valid_in = take ? 1'b1 : (item_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         data_ff <= req_tdata;
         mask_ff <= mask_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;
   assign item_mask  = mask_ff;

endmodule

// ===== sv/rbce_queue.sv =====
// Two-entry queue between the front stage and the edge engine.
module rbce_queue
   import rbce_pkg::*;
#(
   parameter int DW = 132
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  logic [DW-1:0] push_data,
   output logic          pop_valid,
   input  logic          pop,
   output logic [DW-1:0] pop_data
);

   logic [DW-1:0] mem_ff [2];
   logic          wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/rbce_back.sv =====
// Edge engine: per-edge intersection, serial divide, distance compare, result register.
module rbce_back
   import rbce_pkg::*;
#(
   parameter int CW = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   output logic                           item_pop,
   input  logic [8*CW-1:0]                item_data,
   input  logic [3:0]                     item_mask,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [((2*CW+3+7)/8)*8-1:0]    rsp_tdata
);

   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int SW   = PW + 1;
   localparam int CMPW = (PW > FAR_SHIFT + 1) ? PW : FAR_SHIFT + 1;
   localparam int TW   = CMPW + 2;
   localparam int CNTW = $clog2(PW);
   localparam int OW   = ((2 * CW + 3 + 7) / 8) * 8;
   localparam logic [CMPW-1:0] FAR_LIMIT = CMPW'(1) << FAR_SHIFT;

   function automatic logic signed [DW-1:0] sdiff(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
      sdiff = DW'(a) - DW'(b);
   endfunction

   function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
      mag = v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   function automatic logic btw(input logic signed [TW-1:0] v,
                                input logic signed [TW-1:0] a,
                                input logic signed [TW-1:0] b);
      btw = (a <= b) ? (v >= a && v <= b) : (v >= b && v <= a);
   endfunction

   back_state_type state_ff, state_in;

   logic [1:0]        k_ff, k_in;
   logic [8*CW-1:0]   itm_ff, itm_in;
   logic [3:0]        mask_ff, mask_in;
   logic [DW-1:0]     op_a_ff, op_a_in, op_b_ff, op_b_in, dyh_ff, dyh_in;
   logic [DW-1:0]     den_ff, den_in, rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic [PW-1:0]     div_ff, div_in, sq_ff, sq_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]     best_ff, best_in;
   logic              found_ff, found_in;
   logic [CW-1:0]     hx_ff, hx_in, hy_ff, hy_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0]        side_ff, side_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]     rsp_data_ff, rsp_data_in;

   logic signed [CW-1:0] x1, y1, x2, y2, bl, bt, br, bb;
   logic signed [CW-1:0] u1, v1, u2, v2, e, p, q;
   logic signed [CW-1:0] nx1, ny1, nx2, ny2;
   logic signed [DW-1:0] du, dv, den;
   logic [PW-1:0]        prod;
   logic [SW-1:0]        sq_sum;
   logic [DW:0]          r, rsub;
   logic                 ge;
   logic                 far, rnz, on_ray, ok, last, out_free;
   logic signed [TW-1:0] base, qs, tp, tn, t;
   logic signed [CW-1:0] iu, px, py;

   assign x1 = itm_ff[0*CW +: CW];
   assign y1 = itm_ff[1*CW +: CW];
   assign x2 = itm_ff[2*CW +: CW];
   assign y2 = itm_ff[3*CW +: CW];
   assign bl = itm_ff[4*CW +: CW];
   assign bt = itm_ff[5*CW +: CW];
   assign br = itm_ff[6*CW +: CW];
   assign bb = itm_ff[7*CW +: CW];

   assign nx1 = item_data[0*CW +: CW];
   assign ny1 = item_data[1*CW +: CW];
   assign nx2 = item_data[2*CW +: CW];
   assign ny2 = item_data[3*CW +: CW];

   // Horizontal edges run along x at a fixed y; vertical edges swap the axes.
   always_comb begin
      if (!k_ff[1]) begin
         u1 = x1; v1 = y1; u2 = x2; v2 = y2; p = bl; q = br;
         e  = (k_ff == SIDE_TOP) ? bt : bb;
      end else begin
         u1 = y1; v1 = x1; u2 = y2; v2 = x2; p = bt; q = bb;
         e  = (k_ff == SIDE_LEFT) ? bl : br;
      end
      du  = sdiff(u2, u1);
      dv  = sdiff(e, v1);
      den = sdiff(v2, v1);
   end

   assign prod   = op_a_ff * op_b_ff;
   assign sq_sum = SW'(sq_ff) + SW'(prod);

   assign r    = {rem_ff, div_ff[PW-1]};
   assign rsub = r - {1'b0, den_ff};
   assign ge   = (r >= {1'b0, den_ff});

   always_comb begin
      far  = CMPW'(div_ff) > FAR_LIMIT;
      rnz  = (rem_ff != '0);
      base = TW'(u1);
      qs   = $signed(TW'(div_ff));
      tp   = base + qs;
      tn   = base - qs;
      if (rnz && tp < 0) begin
         tp = tp + TW'(1);
      end
      if (rnz && tn > 0) begin
         tn = tn - TW'(1);
      end
      t      = neg_ff ? tn : tp;
      on_ray = ((u1 != u2) && btw(t, TW'(u1), TW'(u2)))
               || btw(TW'(e), TW'(v1), TW'(v2));
      ok     = !far && on_ray && btw(t, TW'(p), TW'(q));
      iu     = t[CW-1:0];
      px     = k_ff[1] ? e : iu;
      py     = k_ff[1] ? iu : e;
   end

   assign last     = (k_ff == SIDE_RIGHT);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign item_pop = (state_ff == ST_IDLE) && item_valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) state_in = ST_LEN1;
         end
         ST_LEN1: state_in = ST_LEN2;
         ST_LEN2: state_in = ST_EDGE;
         ST_EDGE: begin
            if (!mask_ff[k_ff]) state_in = ST_MUL;
            else if (last) state_in = ST_OUT;
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '0) state_in = ST_CHK;
         end
         ST_CHK: begin
            if (ok) state_in = ST_SQ1;
            else if (last) state_in = ST_OUT;
            else state_in = ST_EDGE;
         end
         ST_SQ1: state_in = ST_SQ2;
         ST_SQ2: state_in = last ? ST_OUT : ST_EDGE;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      k_in = k_ff; itm_in = itm_ff; mask_in = mask_ff;
      op_a_in = op_a_ff; op_b_in = op_b_ff; dyh_in = dyh_ff;
      den_in = den_ff; neg_in = neg_ff; div_in = div_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; sq_in = sq_ff; best_in = best_ff; found_in = found_ff;
      hx_in = hx_ff; hy_in = hy_ff; cx_in = cx_ff; cy_in = cy_ff; side_in = side_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            itm_in   = item_data;
            mask_in  = item_mask;
            op_a_in  = mag(sdiff(nx2, nx1));
            op_b_in  = mag(sdiff(nx2, nx1));
            dyh_in   = mag(sdiff(ny2, ny1));
            k_in     = SIDE_TOP;
            found_in = 1'b0;
            hx_in    = '0;
            hy_in    = '0;
            side_in  = SIDE_TOP;
         end
         ST_LEN1: begin
            sq_in   = prod;
            op_a_in = dyh_ff;
            op_b_in = dyh_ff;
         end
         ST_LEN2: begin
            best_in = sq_sum;
         end
         ST_EDGE: begin
            op_a_in = mag(du);
            op_b_in = mag(dv);
            den_in  = mag(den);
            neg_in  = du[DW-1] ^ dv[DW-1] ^ den[DW-1];
            if (mask_ff[k_ff]) k_in = k_ff + 2'd1;
         end
         ST_MUL: begin
            div_in = prod;
            rem_in = '0;
            cnt_in = CNTW'(PW - 1);
         end
         ST_DIV: begin
            div_in = {div_ff[PW-2:0], ge};
            rem_in = ge ? rsub[DW-1:0] : r[DW-1:0];
            cnt_in = cnt_ff - CNTW'(1);
         end
         ST_CHK: begin
            cx_in   = px;
            cy_in   = py;
            op_a_in = mag(sdiff(px, x1));
            op_b_in = mag(sdiff(px, x1));
            dyh_in  = mag(sdiff(py, y1));
            if (!ok) k_in = k_ff + 2'd1;
         end
         ST_SQ1: begin
            sq_in   = prod;
            op_a_in = dyh_ff;
            op_b_in = dyh_ff;
         end
         ST_SQ2: begin
            if (sq_sum <= best_ff) begin
               best_in  = sq_sum;
               found_in = 1'b1;
               hx_in    = cx_ff;
               hy_in    = cy_ff;
               side_in  = k_ff;
            end
            k_in = k_ff + 2'd1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OW'({side_ff, hy_ff, hx_ff, found_ff});
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in; itm_ff <= itm_in; mask_ff <= mask_in;
      op_a_ff <= op_a_in; op_b_ff <= op_b_in; dyh_ff <= dyh_in;
      den_ff <= den_in; neg_ff <= neg_in; div_ff <= div_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; sq_ff <= sq_in; best_ff <= best_in; found_ff <= found_in;
      hx_ff <= hx_in; hy_ff <= hy_in; cx_ff <= cx_in; cy_ff <= cy_in;
      side_ff <= side_in; rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/ray_box_closest_edge_hit.sv =====
// Top level of the ray segment versus box closest edge hit block.
//
//   channel   direction   payload
//   req_      in          ray start, ray end, box corners
//   rsp_      out         hit flag, hit point, edge side
//
// Each request passes through the sequencing states, then visits each edge in turn;
// a parallel or degenerate edge is skipped, any other edge goes through the divide,
// and the distance is compared when its point counts. The edge engine uses a
// one-bit-per-cycle serial divider.
// Reset is synchronous and clears the handshake and sequencer state only.
// A two-entry queue lets new requests enter while the engine works, and the
// result register lets the engine finish while the response is stalled.
module ray_box_closest_edge_hit
   import rbce_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // ray_start_x, ray_start_y, ray_end_x, ray_end_y,
   // box_left, box_top, box_right, box_bottom
   input  logic [8*COORD_WIDTH-1:0]                req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // hit, hit_x, hit_y, hit_side, zero fill
   output logic [((2*COORD_WIDTH+3+7)/8)*8-1:0]    rsp_tdata
);

   localparam int QW = 8 * COORD_WIDTH + 4;

   logic                     f_valid, q_ready, q_valid, q_pop;
   logic [8*COORD_WIDTH-1:0] f_data;
   logic [3:0]               f_mask;
   logic [QW-1:0]            q_data;

   rbce_front #(.CW(COORD_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (f_valid),
      .item_ready (q_ready),
      .item_data  (f_data),
      .item_mask  (f_mask)
   );

   rbce_queue #(.DW(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (q_ready),
      .push_data  ({f_mask, f_data}),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   rbce_back #(.CW(COORD_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_pop   (q_pop),
      .item_data  (q_data[8*COORD_WIDTH-1:0]),
      .item_mask  (q_data[QW-1:8*COORD_WIDTH]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the ray segment versus box closest edge hit block.
module tb
   import rbce_pkg::*;
();

   localparam int W = 16;
   localparam int RW = ((2*W+3+7)/8)*8;

   typedef struct packed {
      logic          hit;
      logic [W-1:0]  hx;
      logic [W-1:0]  hy;
      logic [1:0]    side;
   } hit_type;

   logic           clock = 0;
   logic           reset = 1;
   logic           req_tvalid = 0;
   logic           req_tready;
   logic [8*W-1:0] req_tdata = '0;
   logic           rsp_tvalid;
   logic           rsp_tready = 0;
   logic [RW-1:0]  rsp_tdata;

   hit_type expected_hits[$];
   int      errors = 0;
   bit      sending_done = 0;

   ray_box_closest_edge_hit #(.COORD_WIDTH(W)) u_dut (.*);

   always #1 clock = ~clock;

   function automatic longint magn(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit in_span(longint v, longint a, longint b);
      return a <= b ? (v >= a && v <= b) : (v >= b && v <= a);
   endfunction

   // Line crossing of the ray with the edge v = e spanning u from p to q.
   function automatic bit cross_edge(longint u1, longint v1, longint u2, longint v2,
                                     longint e, longint p, longint q, output longint iu);
      bit neg;
      longint m, d, qm, rm, t;
      iu = 0;
      if (v2 == v1 || p == q) return 0;
      neg = ((u2 - u1 < 0) != (e - v1 < 0)) != (v2 - v1 < 0);
      m = magn(u2 - u1) * magn(e - v1);
      d = magn(v2 - v1);
      qm = m / d;
      rm = m % d;
      if (qm > (64'sd1 <<< FAR_SHIFT)) return 0;
      if (!neg) begin
         t = u1 + qm;
         if (rm != 0 && t < 0) t += 1;
      end else begin
         t = u1 - qm;
         if (rm != 0 && t > 0) t -= 1;
      end
      iu = t;
      return ((u1 != u2 && in_span(t, u1, u2)) || in_span(e, v1, v2)) && in_span(t, p, q);
   endfunction

   function automatic hit_type closest_hit(logic [8*W-1:0] d);
      longint x1, y1, x2, y2, bl, bt, br, bb, px, py, iu, e, d2, best;
      bit ok;
      hit_type r;
      x1 = $signed(d[0*W+:W]); y1 = $signed(d[1*W+:W]);
      x2 = $signed(d[2*W+:W]); y2 = $signed(d[3*W+:W]);
      bl = $signed(d[4*W+:W]); bt = $signed(d[5*W+:W]);
      br = $signed(d[6*W+:W]); bb = $signed(d[7*W+:W]);
      best = (x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1);
      r = '0;
      for (int k = 0; k < 4; k++) begin
         if (k < 2) begin
            e = (k == 0) ? bt : bb;
            ok = cross_edge(x1, y1, x2, y2, e, bl, br, iu);
            px = iu; py = e;
         end else begin
            e = (k == 2) ? bl : br;
            ok = cross_edge(y1, x1, y2, x2, e, bt, bb, iu);
            px = e; py = iu;
         end
         if (ok) begin
            d2 = (px - x1) * (px - x1) + (py - y1) * (py - y1);
            if (d2 <= best) begin
               best = d2;
               r.hit = 1;
               r.hx = px[W-1:0];
               r.hy = py[W-1:0];
               r.side = k[1:0];
            end
         end
      end
      return r;
   endfunction

   function automatic logic [8*W-1:0] pack_req(int sx, int sy, int ex, int ey,
                                               int l, int t, int r, int b);
      return {b[W-1:0], r[W-1:0], t[W-1:0], l[W-1:0], ey[W-1:0], ex[W-1:0],
              sy[W-1:0], sx[W-1:0]};
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 200);
   endfunction

   task automatic send_request(logic [8*W-1:0] d, bit known, hit_type want);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      expected_hits.push_back(known ? want : closest_hit(d));
      req_tdata <= d;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic int rand_coord(bit near);
      if (near) return $urandom_range(0, 400) - 200;
      return $signed(16'($urandom()));
   endfunction

   typedef struct {
      logic [8*W-1:0] d;
      bit             known;
      hit_type        want;
   } stim_row_type;

   initial begin
      stim_row_type rows[$];
      logic [8*W-1:0] d;
      int cx, cy, hw, hh;
      rows.push_back('{pack_req(0, 0, 0, 0, 0, 0, 0, 0), 1, '0});
      rows.push_back('{pack_req(0, -50, 0, 50, -10, -10, 10, 10), 1,
                       '{1'b1, 16'd0, 16'hfff6, SIDE_TOP}});
      rows.push_back('{pack_req(0, 50, 0, -50, -10, -10, 10, 10), 1,
                       '{1'b1, 16'd0, 16'd10, SIDE_BOTTOM}});
      rows.push_back('{pack_req(-50, 0, 50, 0, -10, -10, 10, 10), 1,
                       '{1'b1, 16'hfff6, 16'd0, SIDE_LEFT}});
      rows.push_back('{pack_req(50, 0, -50, 0, -10, -10, 10, 10), 1,
                       '{1'b1, 16'd10, 16'd0, SIDE_RIGHT}});
      rows.push_back('{pack_req(50, 0, -50, 0, 10, 10, -10, -10), 0, '0});
      rows.push_back('{pack_req(0, 0, 5, 5, -10, -10, 10, 10), 0, '0});
      rows.push_back('{pack_req(-50, 0, 50, 0, 0, -10, 0, 10), 0, '0});
      rows.push_back('{pack_req(-50, 20, 50, 20, -10, -10, 10, 10), 1, '0});
      rows.push_back('{pack_req(-32768, -32768, 32767, 32767, -32768, -32768,
                                32767, 32767), 0, '0});
      rows.push_back('{pack_req(32767, -32768, -32768, 32767, -100, -100, 100, 100),
                       0, '0});
      rows.push_back('{pack_req(-32768, 0, -32767, 32767, 0, 0, 100, 100), 0, '0});
      rows.push_back('{pack_req(0, 0, 1, 32767, -32768, 32767, 32767, -32768), 0, '0});
      rows.push_back('{pack_req(3, -7, 11, 13, 0, 0, 9, 9), 0, '0});
      rows.push_back('{pack_req(-3, 7, -11, -13, 0, 0, -9, -9), 0, '0});
      rows.push_back('{pack_req(-20, -20, 20, 20, -10, -10, 10, 10), 0, '0});
      rows.push_back('{pack_req(10, 0, 10, 50, -10, -10, 10, 10), 0, '0});
      rows.push_back('{pack_req(-1, -1, -1, -1, -1, -1, -1, -1), 1, '0});
      repeat (5) @(posedge clock);
      reset <= 0;
      foreach (rows[i]) send_request(rows[i].d, rows[i].known, rows[i].want);
      for (int n = 0; n < 750; n++) begin
         if ($urandom_range(0, 9) < 7) begin
            cx = rand_coord(n % 5 != 0); cy = rand_coord(n % 5 != 0);
            hw = $urandom_range(0, 120); hh = $urandom_range(0, 120);
            if ($urandom_range(0, 9) == 0) hw = 0;
            d = pack_req(cx + rand_coord(1), cy + rand_coord(1),
                         cx + rand_coord(1) * 2, cy + rand_coord(1) * 2,
                         cx - hw, cy - hh, cx + hw, cy + hh);
            if ($urandom_range(0, 7) == 0) d = {d[6*W+:2*W], d[4*W+:2*W], d[0+:4*W]};
         end else begin
            d = {$urandom(), $urandom(), $urandom(), $urandom()};
         end
         send_request(d, 0, '0);
      end
      req_tvalid <= 0;
      sending_done = 1;
   end

   always @(posedge clock) begin
      hit_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[0], rsp_tdata[W:1], rsp_tdata[2*W:W+1], rsp_tdata[2*W+2:2*W+1]};
         if (expected_hits.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            want = expected_hits.pop_front();
            if (got.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
            end
            if (got.hx !== want.hx) begin
               $error("hit_x: expected %0h, got %0h", want.hx, got.hx); errors++;
            end
            if (got.hy !== want.hy) begin
               $error("hit_y: expected %0h, got %0h", want.hy, got.hy); errors++;
            end
            if (got.side !== want.side) begin
               $error("hit_side: expected %0d, got %0d", want.side, got.side); errors++;
            end
         end
      end
   end

   initial begin
      int g;
      forever begin
         g = gap_len();
         rsp_tready <= (g == 0);
         repeat ((g == 0) ? 1 : g) @(posedge clock);
      end
   end

   initial begin
      wait (sending_done);
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (800) @(posedge clock);
      if (errors == 0 && expected_hits.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
